### hw/rtl/npp_pkg.sv
// npp_pkg: shared types and constants for the next-PC predictor.
// Holds the condition table, the sequencer states and the result record.
// No dependencies.
`default_nettype none

package npp_pkg;

  localparam int unsigned REG_COUNT = 15;
  localparam int unsigned REG_INDEX_W = 4;
  localparam logic [REG_INDEX_W-1:0] PC_INDEX = 4'd15;

  // Condition pass table: bit f of entry c is set when condition c holds for NZCV = f.
  localparam logic [0:15][15:0] COND_TABLE = '{
    16'hF0F0, 16'h0F0F, 16'hCCCC, 16'h3333, 16'hFF00, 16'h00FF, 16'hAAAA, 16'h5555,
    16'h0C0C, 16'hF3F3, 16'hAA55, 16'h55AA, 16'h0A05, 16'hF5FA, 16'hFFFF, 16'h0000
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EXEC
  } npp_state_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        from_memory;
    logic [31:0] load_address;
  } npp_result_t;

endpackage

`default_nettype wire

### hw/rtl/npp_regfile.sv
// npp_regfile: general registers r0..r14 in a synchronous RAM, one write port
// and two registered read ports. Valid bits give the zero reset value.
// Depends on npp_pkg.
`default_nettype none

module npp_regfile (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [npp_pkg::REG_INDEX_W-1:0] wr_addr,
  input  wire logic [31:0]                     wr_data,
  input  wire logic                            rd_en,
  input  wire logic [npp_pkg::REG_INDEX_W-1:0] rd_addr_a,
  input  wire logic [npp_pkg::REG_INDEX_W-1:0] rd_addr_b,
  output logic      [31:0]                     rd_data_a,
  output logic      [31:0]                     rd_data_b
);

  logic [31:0]                    mem [npp_pkg::REG_COUNT];
  logic [npp_pkg::REG_COUNT-1:0]  valid;
  logic                           wr_ok;

  assign wr_ok = wr_en && (wr_addr != npp_pkg::PC_INDEX);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_ok) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Index 15 is not stored; the datapath substitutes the PC for it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= (rd_addr_a != npp_pkg::PC_INDEX && valid[rd_addr_a]) ? mem[rd_addr_a] : '0;
      rd_data_b <= (rd_addr_b != npp_pkg::PC_INDEX && valid[rd_addr_b]) ? mem[rd_addr_b] : '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/npp_shifter.sv
// npp_shifter: barrel shifter for the shifted-register operand, immediate
// or register amount, with RRX. Combinational; no dependencies.
`default_nettype none

module npp_shifter (
  input  wire logic [31:0] value,
  input  wire logic [7:0]  amount,
  input  wire logic [1:0]  shift_kind,
  input  wire logic        by_reg,
  input  wire logic        carry,
  output logic      [31:0] result
);

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  logic [4:0]  amt5;
  logic        wide;
  logic [31:0] sign_fill;
  logic [31:0] lsl_v;
  logic [31:0] lsr_v;
  logic [31:0] asr_v;
  logic [63:0] ror_dbl;
  logic [31:0] ror_v;

  assign amt5      = amount[4:0];
  assign wide      = amount[7:5] != 3'd0;
  assign sign_fill = {32{value[31]}};
  assign lsl_v     = value << amt5;
  assign lsr_v     = value >> amt5;
  assign asr_v     = 32'($signed(value) >>> amt5);
  assign ror_dbl   = {value, value} >> amt5;
  assign ror_v     = ror_dbl[31:0];

  always_comb begin
    result = value;
    if (by_reg) begin
      // Zero amount leaves the value unchanged.
      if (amount != 8'd0) begin
        unique case (shift_kind)
          SH_LSL: result = wide ? '0 : lsl_v;
          SH_LSR: result = wide ? '0 : lsr_v;
          SH_ASR: result = wide ? sign_fill : asr_v;
          SH_ROR: result = ror_v;
        endcase
      end
    end else begin
      unique case (shift_kind)
        SH_LSL: result = lsl_v;
        SH_LSR: result = (amt5 == 5'd0) ? '0 : lsr_v;
        SH_ASR: result = (amt5 == 5'd0) ? sign_fill : asr_v;
        SH_ROR: result = (amt5 == 5'd0) ? {carry, value[31:1]} : ror_v;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/npp_resolve.sv
// npp_resolve: condition check, instruction class decode, ALU and address
// adders that form the predicted next PC. Combinational; depends on npp_pkg.
`default_nettype none

module npp_resolve (
  input  wire logic [31:0]          instr,
  input  wire logic [31:0]          pc,
  input  wire logic [3:0]           flags,
  input  wire logic [31:0]          rn_raw,
  input  wire logic [31:0]          rm_value,
  input  wire logic [31:0]          shift_op,
  output npp_pkg::npp_result_t      result
);

  typedef enum logic [3:0] {
    OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
    OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
  } dp_op_t;

  localparam logic [19:0] BX_PATTERN  = 20'h2FFF1;
  localparam logic [19:0] BLX_PATTERN = 20'h2FFF3;

  logic [31:0] pc4;
  logic [31:0] pc8;
  logic        carry;
  logic        cond_ok;
  logic        rd_is_pc;
  logic        rn_is_pc;
  logic [31:0] op1;
  logic [63:0] imm_dbl;
  logic [31:0] op2;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_c;
  logic [31:0] sum;
  logic [31:0] alu_pc;
  logic [31:0] ldr_off;
  logic [31:0] ldr_addr;
  logic [3:0]  list_count;
  logic [6:0]  ldm_up;
  logic [31:0] ldm_off;
  logic [31:0] ldm_addr;
  logic [31:0] branch_pc;
  logic        halfword_ld;
  logic        multiply;
  logic [31:0] npc;
  logic [31:0] addr;
  logic        mem;

  assign pc4      = pc + 32'd4;
  assign pc8      = pc + 32'd8;
  assign carry    = flags[1];
  assign cond_ok  = npp_pkg::COND_TABLE[instr[31:28]][flags];
  assign rd_is_pc = instr[15:12] == npp_pkg::PC_INDEX;
  assign rn_is_pc = instr[19:16] == npp_pkg::PC_INDEX;
  assign op1      = rn_is_pc ? pc8 : rn_raw;

  // Rotated 8-bit immediate: twice the rotate field, zero means no rotate.
  assign imm_dbl  = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> {instr[11:8], 1'b0};
  assign op2      = instr[25] ? imm_dbl[31:0] : shift_op;

  always_comb begin
    add_a = op1;
    add_b = op2;
    add_c = 1'b0;
    unique case (dp_op_t'(instr[24:21]))
      OP_SUB:  begin add_b = ~op2; add_c = 1'b1; end
      OP_RSB:  begin add_a = op2; add_b = ~op1; add_c = 1'b1; end
      OP_ADC:  add_c = carry;
      OP_SBC:  begin add_b = ~op2; add_c = carry; end
      OP_RSC:  begin add_a = op2; add_b = ~op1; add_c = carry; end
      default: ;
    endcase
  end

  assign sum = add_a + add_b + {31'd0, add_c};

  always_comb begin
    unique case (dp_op_t'(instr[24:21]))
      OP_AND: alu_pc = op1 & op2;
      OP_EOR: alu_pc = op1 ^ op2;
      OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC: alu_pc = sum;
      OP_TST, OP_TEQ, OP_CMP, OP_CMN: alu_pc = pc4;
      OP_ORR: alu_pc = op1 | op2;
      OP_MOV: alu_pc = op2;
      OP_BIC: alu_pc = op1 & ~op2;
      OP_MVN: alu_pc = ~op2;
    endcase
  end

  // Single word load: pre-indexed adds the signed offset, post-indexed uses the base.
  assign ldr_off  = instr[25] ? shift_op : {20'd0, instr[11:0]};
  assign ldr_addr = !instr[24] ? op1 : (instr[23] ? op1 + ldr_off : op1 - ldr_off);

  // Block load: PC is the highest word of the list; the base reads r15 as the bare PC.
  assign list_count = 4'($countones(instr[14:0]));
  assign ldm_up     = {1'b0, list_count, 2'b00} + (instr[24] ? 7'd4 : 7'd0);
  assign ldm_off    = instr[23] ? {25'd0, ldm_up} : (instr[24] ? 32'hFFFF_FFFC : 32'd0);
  assign ldm_addr   = (rn_is_pc ? pc : rn_raw) + ldm_off;

  assign branch_pc  = pc8 + {{6{instr[23]}}, instr[23:0], 2'b00};

  assign halfword_ld = instr[27:24] == 4'h1 && instr[4] && instr[7] && instr[20]
                       && instr[6:5] != 2'b00;
  assign multiply    = instr[25:22] == 4'h0 && instr[7:4] == 4'h9;

  always_comb begin
    npc  = pc4;
    addr = '0;
    mem  = 1'b0;
    if (cond_ok) begin
      unique case (instr[27:24])
        4'h0, 4'h1, 4'h2, 4'h3: begin
          priority if (!rd_is_pc || halfword_ld || multiply) begin
            npc = pc4;
          end else if (instr[23:4] == BX_PATTERN) begin
            npc = {rm_value[31:1], 1'b0};
          end else if (instr[23:4] == BLX_PATTERN) begin
            npc = rm_value;
          end else begin
            npc = alu_pc;
          end
        end
        4'h4, 4'h5, 4'h6, 4'h7: begin
          if (instr[20] && rd_is_pc && !instr[22]) begin
            mem  = 1'b1;
            addr = ldr_addr;
          end
        end
        4'h8, 4'h9: begin
          if (instr[20] && instr[15]) begin
            mem  = 1'b1;
            addr = ldm_addr;
          end
        end
        4'hA, 4'hB: npc = branch_pc;
        default: ;
      endcase
    end
  end

  assign result.next_pc      = mem ? '0 : npc;
  assign result.from_memory  = mem;
  assign result.load_address = mem ? addr : '0;

endmodule

`default_nettype wire

### hw/rtl/next_pc_predictor_top.sv
// next_pc_predictor_top: next-PC predictor for 32-bit ARM-mode instructions.
// Instantiates npp_regfile, npp_shifter and npp_resolve; uses npp_pkg.
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, reg_index, reg_value, instruction,
//                                  current_pc, status_flags
// output    out_valid / out_ready  next_pc, from_memory, load_address
//
// A register-write item gives no result.
// A predict item goes through idle, shift and exec: the register RAM has two read ports,
// so Rm and Rs are read first, then Rn, and exec resolves the address into the output register.
// Reset clears the per-entry valid bits at once, so every register reads zero; no sweep.
// A full output register holds the block in its last step; an item is taken while a result waits.
// Items are handled one at a time, so a write is always in the RAM before the next read.

module next_pc_predictor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        kind,
  input  wire logic [3:0]  reg_index,
  input  wire logic [31:0] reg_value,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] current_pc,
  input  wire logic [3:0]  status_flags,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      next_pc,
  output logic             from_memory,
  output logic [31:0]      load_address
);

  npp_pkg::npp_state_t  state;
  npp_pkg::npp_state_t  state_next;
  npp_pkg::npp_result_t result;

  logic        accept;
  logic        out_load;
  logic        rd_en;
  logic [3:0]  rd_addr_a;
  logic [31:0] rd_data_a;
  logic [31:0] rd_data_b;

  // Held copy of the predict item.
  logic [31:0] held_instr;
  logic [31:0] held_pc;
  logic [3:0]  held_flags;

  // Shift step values.
  logic [31:0] pc8;
  logic [31:0] pc12;
  logic [31:0] shift_in;
  logic [31:0] rs_value;
  logic [7:0]  shift_amt;
  logic [31:0] shift_out;
  logic [31:0] rm_value_next;
  logic [31:0] shift_op;
  logic [31:0] rm_value;

  assign accept = in_valid && in_ready;

  // Sequencer: idle takes items, shift reads Rn, exec waits for room in the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      npp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && kind) begin
          state_next = npp_pkg::ST_SHIFT;
        end
      end
      npp_pkg::ST_SHIFT: begin
        state_next = npp_pkg::ST_EXEC;
      end
      npp_pkg::ST_EXEC: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = npp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = npp_pkg::ST_IDLE;
      end
    endcase
  end

  // Read Rm and Rs straight off the input port at accept, then Rn during the shift step.
  assign rd_en     = (accept && kind) || (state == npp_pkg::ST_SHIFT);
  assign rd_addr_a = (state == npp_pkg::ST_SHIFT) ? held_instr[19:16] : instruction[3:0];

  npp_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (accept && !kind),
    .wr_addr   (reg_index),
    .wr_data   (reg_value),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (instruction[11:8]),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (accept && kind) begin
      held_instr <= instruction;
      held_pc    <= current_pc;
      held_flags <= status_flags;
    end
  end

  // r15 reads as PC+8, or PC+12 for Rm of a register-shifted operand.
  assign pc8      = held_pc + 32'd8;
  assign pc12     = held_pc + 32'd12;
  assign shift_in = (held_instr[3:0] == npp_pkg::PC_INDEX) ? (held_instr[4] ? pc12 : pc8)
                                                           : rd_data_a;
  assign rs_value = (held_instr[11:8] == npp_pkg::PC_INDEX) ? pc8 : rd_data_b;
  assign shift_amt = held_instr[4] ? rs_value[7:0] : {3'b000, held_instr[11:7]};
  assign rm_value_next = (held_instr[3:0] == npp_pkg::PC_INDEX) ? pc8 : rd_data_a;

  npp_shifter u_shifter (
    .value      (shift_in),
    .amount     (shift_amt),
    .shift_kind (held_instr[6:5]),
    .by_reg     (held_instr[4]),
    .carry      (held_flags[1]),
    .result     (shift_out)
  );

  // Hold the shifted operand and the branch-exchange target for the exec step.
  always_ff @(posedge clk) begin
    if (state == npp_pkg::ST_SHIFT) begin
      shift_op <= shift_out;
      rm_value <= rm_value_next;
    end
  end

  npp_resolve u_resolve (
    .instr    (held_instr),
    .pc       (held_pc),
    .flags    (held_flags),
    .rn_raw   (rd_data_a),
    .rm_value (rm_value),
    .shift_op (shift_op),
    .result   (result)
  );

  // Output register: load on exec, drop valid once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      next_pc      <= result.next_pc;
      from_memory  <= result.from_memory;
      load_address <= result.load_address;
    end
  end

  // A predict item walks through the shift step into exec without gaps.
  a_predict_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> state == npp_pkg::ST_SHIFT ##1 state == npp_pkg::ST_EXEC)
    else $error("predict item did not advance through shift and exec");

  // Leaving exec always loads the output register and returns to idle.
  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    state == npp_pkg::ST_EXEC && (!out_valid || out_ready)
    |=> out_valid && state == npp_pkg::ST_IDLE)
    else $error("exec step did not deliver its result");

  // A result carries either a next PC or a load address, never both.
  a_result_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (from_memory ? next_pc == 32'd0 : load_address == 32'd0))
    else $error("result carries both a next PC and a load address");

endmodule

`default_nettype wire

### sim/npp_tb_pkg.sv
// npp_tb_pkg: item kinds shared by the next-PC predictor testbench files.
// No dependencies.
package npp_tb_pkg;

  typedef enum logic {
    ITEM_WRITE   = 1'b0,
    ITEM_PREDICT = 1'b1
  } item_kind_e;

endpackage

### sim/next_pc_checker.sv
// next_pc_checker: watches both channels of next_pc_predictor_top, predicts the
// next-PC result of every predict item and compares it field by field.
// Depends on npp_pkg (condition table, result record) and npp_tb_pkg.
module next_pc_checker
  import npp_pkg::*;
  import npp_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [3:0]  reg_index,
  input  logic [31:0] reg_value,
  input  logic [31:0] instruction,
  input  logic [31:0] current_pc,
  input  logic [3:0]  status_flags,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] next_pc,
  input  logic        from_memory,
  input  logic [31:0] load_address,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef enum logic [3:0] {
    DP_AND, DP_EOR, DP_SUB, DP_RSB, DP_ADD, DP_ADC, DP_SBC, DP_RSC,
    DP_TST, DP_TEQ, DP_CMP, DP_CMN, DP_ORR, DP_MOV, DP_BIC, DP_MVN
  } dp_op_e;

  typedef enum logic [1:0] {SH_LSL, SH_LSR, SH_ASR, SH_ROR} shift_e;

  // Instruction classes by bits 27:26.
  localparam logic [1:0]  CLS_DATA   = 2'b00;
  localparam logic [1:0]  CLS_LOAD   = 2'b01;
  localparam logic [1:0]  CLS_BLOCK  = 2'b10;
  localparam logic [19:0] BX_MARK    = 20'h2FFF1;
  localparam logic [19:0] BLX_MARK   = 20'h2FFF3;
  localparam logic [3:0]  MUL_MARK   = 4'b1001;

  logic [31:0] gpr_shadow [REG_COUNT];
  npp_result_t expected_targets [$];
  int unsigned mismatches = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] read_gpr(input logic [3:0] idx, input logic [31:0] pc_val);
    if (idx == PC_INDEX) return pc_val;
    return gpr_shadow[idx];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    if (s == 5'd0) return v;
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    return v[31] ? ~((~v) >> s) : (v >> s);
  endfunction

  function automatic logic [31:0] shift_operand(input logic [31:0] ins, input logic [31:0] pc,
                                                input logic carry);
    logic [31:0] v;
    logic [31:0] rs_val;
    logic [7:0]  amt;
    shift_e      sh;
    sh = shift_e'(ins[6:5]);
    if (ins[4]) begin
      // Register-specified amount: Rm reads PC+12, only Rs[7:0] counts.
      v = read_gpr(ins[3:0], pc + 32'd12);
      rs_val = read_gpr(ins[11:8], pc + 32'd8);
      amt = rs_val[7:0];
      if (amt == 8'd0) return v;
      case (sh)
        SH_LSL:  return (amt >= 8'd32) ? 32'd0 : v << amt;
        SH_LSR:  return (amt >= 8'd32) ? 32'd0 : v >> amt;
        SH_ASR:  return (amt >= 8'd32) ? {32{v[31]}} : asr32(v, amt[4:0]);
        default: return ror32(v, amt[4:0]);
      endcase
    end
    v = read_gpr(ins[3:0], pc + 32'd8);
    amt = {3'd0, ins[11:7]};
    // Immediate amount of zero: LSR/ASR mean 32, ROR means RRX.
    case (sh)
      SH_LSL:  return v << amt;
      SH_LSR:  return (amt == 8'd0) ? 32'd0 : v >> amt;
      SH_ASR:  return (amt == 8'd0) ? {32{v[31]}} : asr32(v, amt[4:0]);
      default: return (amt == 8'd0) ? {carry, v[31:1]} : ror32(v, amt[4:0]);
    endcase
  endfunction

  function automatic npp_result_t predict_next_pc(input logic [31:0] ins, input logic [31:0] pc,
                                                  input logic [3:0] nzcv);
    npp_result_t res;
    logic [31:0] target;
    logic [31:0] addr;
    logic [31:0] op1;
    logic [31:0] op2;
    logic [31:0] base;
    logic [31:0] off;
    logic        carry;
    logic        mem;
    carry  = nzcv[1];
    target = pc + 32'd4;
    addr   = 32'd0;
    mem    = 1'b0;
    if (COND_TABLE[ins[31:28]][nzcv]) begin
      case (ins[27:26])
        CLS_DATA: begin
          // Skip halfword/signed loads and multiplies that name PC.
          if (ins[15:12] == PC_INDEX
              && !(!ins[25] && ins[24] && ins[4] && ins[7] && ins[20] && ins[6:5] != 2'b00)
              && !(!ins[25] && ins[24:22] == 3'b000 && ins[7:4] == MUL_MARK)) begin
            if (ins[23:4] == BX_MARK) begin
              target = read_gpr(ins[3:0], pc + 32'd8) & ~32'd1;
            end else if (ins[23:4] == BLX_MARK) begin
              target = read_gpr(ins[3:0], pc + 32'd8);
            end else begin
              op1 = read_gpr(ins[19:16], pc + 32'd8);
              if (ins[25]) op2 = ror32({24'd0, ins[7:0]}, {ins[11:8], 1'b0});
              else op2 = shift_operand(ins, pc, carry);
              case (dp_op_e'(ins[24:21]))
                DP_AND:  target = op1 & op2;
                DP_EOR:  target = op1 ^ op2;
                DP_SUB:  target = op1 - op2;
                DP_RSB:  target = op2 - op1;
                DP_ADD:  target = op1 + op2;
                DP_ADC:  target = op1 + op2 + {31'd0, carry};
                DP_SBC:  target = op1 - op2 + {31'd0, carry} - 32'd1;
                DP_RSC:  target = op2 - op1 + {31'd0, carry} - 32'd1;
                DP_ORR:  target = op1 | op2;
                DP_MOV:  target = op2;
                DP_BIC:  target = op1 & ~op2;
                DP_MVN:  target = ~op2;
                default: ;
              endcase
            end
          end
        end
        CLS_LOAD: begin
          if (ins[20] && ins[15:12] == PC_INDEX && !ins[22]) begin
            base = read_gpr(ins[19:16], pc + 32'd8);
            off  = ins[25] ? shift_operand(ins, pc, carry) : {20'd0, ins[11:0]};
            if (!ins[23]) off = 32'd0 - off;
            if (ins[24]) base = base + off;
            mem  = 1'b1;
            addr = base;
          end
        end
        CLS_BLOCK: begin
          if (!ins[25]) begin
            if (ins[20] && ins[15]) begin
              // Block load with PC in the list; base r15 reads the bare PC.
              base = read_gpr(ins[19:16], pc);
              if (ins[23]) off = (32'($countones(ins[14:0])) << 2) + (ins[24] ? 32'd4 : 32'd0);
              else off = ins[24] ? 32'd0 - 32'd4 : 32'd0;
              mem  = 1'b1;
              addr = base + off;
            end
          end else begin
            target = pc + 32'd8 + {{6{ins[23]}}, ins[23:0], 2'b00};
          end
        end
        default: ;
      endcase
    end
    res.next_pc      = mem ? 32'd0 : target;
    res.from_memory  = mem;
    res.load_address = mem ? addr : 32'd0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    npp_result_t want;
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) gpr_shadow[i] = 32'd0;
      expected_targets.delete();
    end else begin
      // Check results before taking new items: a result never stems from
      // an item accepted at the same edge.
      if (out_valid && out_ready) begin
        if (expected_targets.size() == 0) begin
          $display("%0t: result with none expected: next_pc %h from_memory %b load_address %h",
                   $time, next_pc, from_memory, load_address);
          mismatches++;
        end else begin
          want = expected_targets.pop_front();
          if (next_pc !== want.next_pc) begin
            $display("%0t: next_pc expected %h, got %h", $time, want.next_pc, next_pc);
            mismatches++;
          end
          if (from_memory !== want.from_memory) begin
            $display("%0t: from_memory expected %b, got %b", $time, want.from_memory,
                     from_memory);
            mismatches++;
          end
          if (load_address !== want.load_address) begin
            $display("%0t: load_address expected %h, got %h", $time, want.load_address,
                     load_address);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (kind == ITEM_PREDICT)
          expected_targets.push_back(predict_next_pc(instruction, current_pc, status_flags));
        else if (reg_index != PC_INDEX)
          gpr_shadow[reg_index] = reg_value;
      end
    end
    fail_count  <= mismatches;
    outstanding <= expected_targets.size();
  end

endmodule

### sim/testbench.sv
// testbench: drives next_pc_predictor_top with directed and random items and
// gives the verdict; prediction and comparison live in next_pc_checker.
// Depends on npp_pkg, npp_tb_pkg, next_pc_checker and the block's RTL.
module testbench;
  import npp_pkg::*;
  import npp_tb_pkg::*;

  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned ITEMS_PER_PHASE = 465;
  localparam int unsigned HOLD_CYCLES     = 200;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  // Idle percentages per random phase: none, sender only, receiver only, both.
  localparam int unsigned PHASE_IDLE [4]  = '{0, 47, 0, 21};
  localparam int unsigned PHASE_STALL [4] = '{0, 0, 47, 21};

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [3:0]  reg_index = 4'd0;
  logic [31:0] reg_value = 32'd0;
  logic [31:0] instruction = 32'd0;
  logic [31:0] current_pc = 32'd0;
  logic [3:0]  status_flags = 4'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] next_pc;
  logic        from_memory;
  logic [31:0] load_address;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // Set by the stimulus to request one long receiver hold-off; cleared by the receiver.
  bit          hold_armed = 1'b0;

  next_pc_predictor_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .reg_index    (reg_index),
    .reg_value    (reg_value),
    .instruction  (instruction),
    .current_pc   (current_pc),
    .status_flags (status_flags),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_pc      (next_pc),
    .from_memory  (from_memory),
    .load_address (load_address)
  );

  next_pc_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .reg_index    (reg_index),
    .reg_value    (reg_value),
    .instruction  (instruction),
    .current_pc   (current_pc),
    .status_flags (status_flags),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .next_pc      (next_pc),
    .from_memory  (from_memory),
    .load_address (load_address),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random by stall_pct; on request drop ready for a long
  // stretch so the output register fills and the block stops taking items.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Cycle counter: end the run if the stimulus or the drain hangs.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("next_pc_predictor_top regression: fail");
    $finish;
  end

  // Offer one item; idle first at random by idle_pct. Return at the edge that
  // accepts it. Signals read right after the edge still hold pre-edge values.
  task automatic offer_item(input item_kind_e k, input logic [3:0] idx, input logic [31:0] val,
                            input logic [31:0] ins, input logic [31:0] pc,
                            input logic [3:0] flags);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    reg_index    <= idx;
    reg_value    <= val;
    instruction  <= ins;
    current_pc   <= pc;
    status_flags <= flags;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Register write; the predict-only fields carry noise.
  task automatic write_gpr(input logic [3:0] idx, input logic [31:0] val);
    offer_item(ITEM_WRITE, idx, val, $urandom, $urandom, 4'($urandom_range(15)));
  endtask

  // Predict item; the write-only fields carry noise.
  task automatic predict_at(input logic [31:0] ins, input logic [31:0] pc,
                            input logic [3:0] flags);
    offer_item(ITEM_PREDICT, 4'($urandom_range(15)), $urandom, ins, pc, flags);
  endtask

  // Hold the sender until every expected result is back, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register values biased toward shift amounts and sign extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0, 1:    return 32'($urandom_range(40));
      // Low byte a multiple of 32: register shifts by 32, 64, 96 or none.
      2:       return ($urandom & 32'hFFFF_FF00) | 32'($urandom_range(3) * 32);
      3: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed PC-changing instructions with random content, some noise.
  function automatic logic [31:0] pick_instruction();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(19))
      0, 1, 2: ;
      // Data processing with Rd = PC; operand form, opcode and registers random.
      3, 4, 5, 6, 7, 8, 9: begin
        w[27:26] = 2'b00;
        w[15:12] = PC_INDEX;
      end
      // BX or BLX.
      10, 11: w = {4'h0, 8'h12, 12'hFFF, (($urandom_range(1) != 0) ? 4'b0011 : 4'b0001),
                   w[3:0]};
      // Single load to PC, mostly word loads.
      12, 13, 14: begin
        w[27:26] = 2'b01;
        w[15:12] = PC_INDEX;
        w[20] = ($urandom_range(7) != 0);
        w[22] = ($urandom_range(3) == 0);
      end
      // Block load, mostly with PC in the list.
      15, 16: begin
        w[27:25] = 3'b100;
        w[20] = ($urandom_range(7) != 0);
        w[15] = ($urandom_range(7) != 0);
      end
      17, 18: w[27:25] = 3'b101;
      // Multiply and halfword-load space naming PC.
      default: begin
        w[27:25] = 3'b000;
        w[7] = 1'b1;
        w[4] = 1'b1;
        w[15:12] = PC_INDEX;
      end
    endcase
    if ($urandom_range(2) == 0) w[31:28] = 4'hE;
    return w;
  endfunction

  initial begin : stimulus
    logic [31:0] pc0;
    pc0 = 32'h0000_8000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: seed registers with extremes and shift amounts.
    write_gpr(4'd0, 32'hFFFF_FFFF);
    write_gpr(4'd1, 32'h8000_0000);
    write_gpr(4'd2, 32'h0000_0020);
    write_gpr(4'd4, 32'h0000_0121);
    write_gpr(PC_INDEX, 32'h1234_5678);  // ignored, no result

    predict_at(32'h0A00_0010, pc0, 4'h0);          // EQ with Z clear: falls through
    predict_at(32'hEA7F_FFFF, 32'hFFFF_FFFC, 4'h0); // B, farthest forward, wraps
    predict_at(32'hEB80_0000, pc0, 4'h0);          // BL, farthest back
    predict_at(32'hE12F_FF10, pc0, 4'h0);          // BX r0 clears bit 0
    predict_at(32'hE12F_FF34, pc0, 4'h0);          // BLX r4 keeps bit 0
    predict_at(32'hE3A0_F0FF, pc0, 4'h0);          // MOV pc, #imm with rotate zero
    predict_at(32'hE3A0_F1FF, pc0, 4'h0);          // MOV pc, #imm rotated by 2
    predict_at(32'hE1A0_F020, pc0, 4'h0);          // LSR #0 means 32
    predict_at(32'hE1A0_F041, pc0, 4'h0);          // ASR #0 fills with sign
    predict_at(32'hE1A0_F061, pc0, 4'h2);          // ROR #0 is RRX with C set
    predict_at(32'hE1A0_F211, pc0, 4'h0);          // LSL by register 32
    predict_at(32'hE1A0_F451, pc0, 4'h0);          // ASR by register 33
    predict_at(32'hE1A0_F270, pc0, 4'h0);          // ROR by register 32 keeps value
    predict_at(32'hE1A0_F31F, pc0, 4'h0);          // Rm = PC with register shift of 0
    predict_at(32'hE0C0_F001, pc0, 4'h0);          // SBC with C clear
    predict_at(32'hE0E0_F001, pc0, 4'h2);          // RSC with C set
    predict_at(32'hE150_F001, pc0, 4'h0);          // CMP naming PC falls through
    predict_at(32'hE000_F091, pc0, 4'h0);          // multiply form falls through
    predict_at(32'hE1DF_F0B0, pc0, 4'h0);          // halfword load to PC falls through
    predict_at(32'hE510_F004, pc0, 4'h0);          // LDR pc, [r0, #-4]
    predict_at(32'hE79F_F102, pc0, 4'h0);          // LDR pc, [pc, r2, LSL #2]
    predict_at(32'hE89F_8000, pc0, 4'h0);          // LDM with base PC
    predict_at(32'hE910_8000, pc0, 4'h0);          // LDMDB
    drain_results();

    // Random phases; in the first, hold the receiver off halfway while the
    // sender keeps offering items, and drain at the end of each phase.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = PHASE_IDLE[ph];
      stall_pct = PHASE_STALL[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == ITEMS_PER_PHASE / 2) hold_armed = 1'b1;
        if ($urandom_range(99) < 35)
          write_gpr(4'($urandom_range(15)), pick_value());
        else
          predict_at(pick_instruction(), $urandom, 4'($urandom_range(15)));
      end
      drain_results();
    end

    if (fail_count == 0)
      $display("next_pc_predictor_top regression: pass");
    else
      $display("next_pc_predictor_top regression: fail");
    $finish;
  end

endmodule

### files.f
hw/rtl/npp_pkg.sv
hw/rtl/npp_regfile.sv
hw/rtl/npp_shifter.sv
hw/rtl/npp_resolve.sv
hw/rtl/next_pc_predictor_top.sv
sim/npp_tb_pkg.sv
sim/next_pc_checker.sv
sim/testbench.sv
